@@ sv/fat_volume_geometry_top_assert.svh @@
// Assertion macros for the FAT volume geometry block.
// Included by fat_volume_geometry_top; needs no other file.
`ifndef FAT_VOLUME_GEOMETRY_TOP_ASSERT_SVH
`define FAT_VOLUME_GEOMETRY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define FVG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fat_volume_geometry: assertion failed");
// Next-cycle implication, disabled while in reset.
`define FVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fat_volume_geometry: assertion failed");
`else
`define FVG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FVG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/fvg_pkg.sv @@
// Types and constants of the FAT volume geometry block.
// Stands alone; used by fat_volume_geometry_top.
`timescale 1ns / 1ps
package fvg_pkg;

  localparam logic [7:0] JMP_SHORT = 8'hEB;
  localparam logic [7:0] JMP_NEAR  = 8'hE9;

  localparam int unsigned ROOT_ENTRY_BYTES = 32;

  localparam logic [31:0] FAT12_CLUSTER_LIMIT = 32'd4085;
  localparam logic [31:0] FAT16_CLUSTER_LIMIT = 32'd65525;
  localparam logic [31:0] FAT32_CLUSTER_LIMIT = 32'd268435445;

  localparam logic [27:0] EOC_FAT12 = 28'h0000FF7;
  localparam logic [27:0] EOC_FAT16 = 28'h000FFF7;
  localparam logic [27:0] EOC_FAT32 = 28'hFFFFFF7;

  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

  localparam int unsigned ROOT_LEN_W = 21;

  // Divider pipeline shape: quotient bits resolved per register stage.
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned ROOT_DIV_BITS   = 22;
  localparam int unsigned CLUS_DIV_BITS   = 32;
  localparam int unsigned ROOT_STAGES     = ROOT_DIV_BITS / STEPS_PER_STAGE;
  localparam int unsigned CLUS_STAGES     = CLUS_DIV_BITS / STEPS_PER_STAGE;

  // Stage map: prepare, root divider, two adder stages, cluster divider.
  localparam int unsigned ADD_DSTART  = 1 + ROOT_STAGES;
  localparam int unsigned ADD_DCOUNT  = ADD_DSTART + 1;
  localparam int unsigned CLUS_FIRST  = ADD_DCOUNT + 1;
  localparam int unsigned NUM_STAGES  = CLUS_FIRST + CLUS_STAGES;

  typedef enum logic [1:0] {
    KIND_FAT12     = 2'd0,
    KIND_FAT16     = 2'd1,
    KIND_FAT32     = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } fvg_kind_e;

  typedef struct packed {
    logic [7:0]  jump_opcode;
    logic [15:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] total_sectors_small;
    logic [31:0] total_sectors_large;
    logic [15:0] fat_size_small;
    logic [31:0] fat_size_large;
    logic [31:0] root_start_cluster;
    logic        want_writable;
  } fvg_req_t;

  typedef struct packed {
    logic        volume_valid;
    fvg_kind_e   fat_kind;
    logic        writable;
    logic [31:0] sectors_in_volume;
    logic [31:0] fat_length;
    logic [20:0] root_dir_length;
    logic [15:0] fat_start_sector;
    logic [31:0] data_start_sector;
    logic [31:0] data_sector_count;
    logic [31:0] cluster_count;
    logic [31:0] root_first_sector;
    logic [27:0] chain_end_marker;
  } fvg_res_t;

  // Working record carried down the pipeline.
  typedef struct packed {
    logic                  bad;
    logic                  want_writable;
    logic [7:0]            spc;
    logic [15:0]           bps;
    logic [15:0]           rsv;
    logic [31:0]           total;
    logic [31:0]           fatlen;
    logic [31:0]           fat_prod;
    logic [31:0]           root_prod;
    logic [31:0]           num;
    logic [15:0]           rem;
    logic [ROOT_LEN_W-1:0] rootlen;
    logic [31:0]           dstart;
    logic [31:0]           dcount;
    logic [31:0]           rfirst_fixed;
    logic [31:0]           rfirst_fat32;
  } fvg_work_t;

endpackage

@@ sv/fat_volume_geometry_top.sv @@
// FAT volume geometry: pipelined computation of volume layout from boot-sector fields.
// Depends on fvg_pkg and fat_volume_geometry_top_assert.svh.
`timescale 1ns / 1ps
// Usage
//   Input channel: in_valid_i / in_stall_o carry one request (in_req_i) holding the
//   extracted boot-sector fields. A request is taken at a rising edge with valid high
//   and stall low.
//   Output channel: out_valid_o / out_stall_i carry one result (out_res_o) per request,
//   in request order.
//   Throughput: one request per cycle, sustained, while the receiver does not stall.
//   Pipeline: the length is set by the two restoring dividers (root directory length
//   over bytes per sector, then data sectors over sectors per cluster), each resolving
//   two quotient bits per register stage: 11 plus 16 stages, with a preparation stage,
//   two adder stages and the output register around them.
//   Stall: while a result waits in the output register and the receiver stalls, every
//   stage holds and in_stall_o is raised; nothing is dropped or repeated.
//   Reset: asynchronous, active low; clears all valid bits, so the block comes up empty
//   and ready.
module fat_volume_geometry_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fvg_pkg::fvg_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fvg_pkg::fvg_res_t out_res_o
);
  import fvg_pkg::*;

`include "fat_volume_geometry_top_assert.svh"

  // Select the 16/32-bit fields, form the root dividend and both products.
  function automatic fvg_work_t prep(fvg_req_t r);
    fvg_work_t w;
    logic [ROOT_DIV_BITS-1:0] dividend;
    w = '0;
    w.bad = !(r.jump_opcode == JMP_SHORT || r.jump_opcode == JMP_NEAR) ||
            (r.sector_bytes == '0) || (r.cluster_sectors == '0);
    w.want_writable = r.want_writable;
    w.spc    = r.cluster_sectors;
    w.bps    = r.sector_bytes;
    w.rsv    = r.reserved_sectors;
    w.total  = (r.total_sectors_small == '0) ? r.total_sectors_large
                                              : {16'd0, r.total_sectors_small};
    w.fatlen = (r.fat_size_small == '0) ? r.fat_size_large
                                         : {16'd0, r.fat_size_small};
    w.fat_prod  = 32'(r.fat_copies) * w.fatlen;
    w.root_prod = (r.root_start_cluster - FIRST_DATA_CLUSTER) *
                  32'(r.cluster_sectors);
    // Round up: entries * 32 + (bps - 1), divided by bps further down.
    dividend = ROOT_DIV_BITS'(r.root_entries) * ROOT_DIV_BITS'(ROOT_ENTRY_BYTES) +
               ROOT_DIV_BITS'(r.sector_bytes) - ROOT_DIV_BITS'(1);
    w.num = 32'(dividend);
    w.rem = '0;
    return w;
  endfunction

  // Restoring division over bytes per sector; quotient shifts into num.
  function automatic fvg_work_t root_stage(fvg_work_t w);
    fvg_work_t n;
    logic [16:0] trial;
    logic        qbit;
    n = w;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      trial = {n.rem, n.num[ROOT_DIV_BITS-1]};
      qbit  = (trial >= {1'b0, n.bps});
      if (qbit) begin
        n.rem = 16'(trial - {1'b0, n.bps});
      end else begin
        n.rem = trial[15:0];
      end
      n.num = {n.num[30:0], qbit};
    end
    return n;
  endfunction

  // Restoring division over sectors per cluster.
  function automatic fvg_work_t clus_stage(fvg_work_t w);
    fvg_work_t n;
    logic [8:0] trial;
    logic       qbit;
    n = w;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      trial = {n.rem[7:0], n.num[31]};
      qbit  = (trial >= {1'b0, n.spc});
      if (qbit) begin
        n.rem = {8'd0, 8'(trial - {1'b0, n.spc})};
      end else begin
        n.rem = {8'd0, trial[7:0]};
      end
      n.num = {n.num[30:0], qbit};
    end
    return n;
  endfunction

  function automatic fvg_work_t dstart_stage(fvg_work_t w);
    fvg_work_t n;
    n = w;
    n.rootlen = w.num[ROOT_LEN_W-1:0];
    n.dstart  = 32'(w.rsv) + w.fat_prod + 32'(n.rootlen);
    return n;
  endfunction

  function automatic fvg_work_t dcount_stage(fvg_work_t w);
    fvg_work_t n;
    n = w;
    n.dcount       = w.total - w.dstart;
    n.rfirst_fixed = w.dstart - 32'(w.rootlen);
    n.rfirst_fat32 = w.root_prod + w.dstart;
    n.num          = n.dcount;
    n.rem          = '0;
    return n;
  endfunction

  // Classify by cluster count; a rejected boot sector gives an all-zero result.
  function automatic fvg_res_t finish(fvg_work_t w);
    fvg_res_t o;
    o = '0;
    if (!w.bad) begin
      o.volume_valid = 1'b1;
      o.writable     = w.want_writable;
      if (w.num < FAT12_CLUSTER_LIMIT) begin
        o.fat_kind         = KIND_FAT12;
        o.writable         = 1'b0;
        o.chain_end_marker = EOC_FAT12;
      end else if (w.num < FAT16_CLUSTER_LIMIT) begin
        o.fat_kind         = KIND_FAT16;
        o.chain_end_marker = EOC_FAT16;
      end else if (w.num < FAT32_CLUSTER_LIMIT) begin
        o.fat_kind         = KIND_FAT32;
        o.chain_end_marker = EOC_FAT32;
      end else begin
        o.fat_kind         = KIND_TOO_LARGE;
        o.volume_valid     = 1'b0;
        o.chain_end_marker = EOC_FAT32;
      end
      o.sectors_in_volume = w.total;
      o.fat_length        = w.fatlen;
      o.root_dir_length   = w.rootlen;
      o.fat_start_sector  = w.rsv;
      o.data_start_sector = w.dstart;
      o.data_sector_count = w.dcount;
      o.cluster_count     = w.num;
      o.root_first_sector = (o.fat_kind == KIND_FAT32) ? w.rfirst_fat32 : w.rfirst_fixed;
    end
    return o;
  endfunction

  logic [NUM_STAGES-1:0] valid_q;
  fvg_work_t             work_q [NUM_STAGES];
  fvg_work_t             work_d [NUM_STAGES];
  logic                  out_valid_q;
  fvg_res_t              out_res_q;
  logic                  adv;

  // Whole pipeline moves together unless a result waits on a stalled receiver.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_prep
      assign work_d[k] = prep(in_req_i);
    end else if (k < ADD_DSTART) begin : g_root
      assign work_d[k] = root_stage(work_q[k-1]);
    end else if (k == ADD_DSTART) begin : g_dstart
      assign work_d[k] = dstart_stage(work_q[k-1]);
    end else if (k == ADD_DCOUNT) begin : g_dcount
      assign work_d[k] = dcount_stage(work_q[k-1]);
    end else begin : g_clus
      assign work_d[k] = clus_stage(work_q[k-1]);
    end

    // Payload registers: advance with the pipeline, no reset.
    always_ff @(posedge clk_i) begin
      if (adv) begin
        work_q[k] <= work_d[k];
      end
    end
  end

  // Valid bits travel alongside the payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q     <= {valid_q[NUM_STAGES-2:0], in_valid_i};
      out_valid_q <= valid_q[NUM_STAGES-1];
    end
  end

  // Output register: holds the result while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= finish(work_q[NUM_STAGES-1]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // A frozen pipeline keeps every valid bit.
  `FVG_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, !adv, $stable(valid_q))
  // FAT12 is always mounted read-only.
  `FVG_ASSERT_IMPLY(a_fat12_read_only, clk_i, rst_ni,
    out_valid_o && out_res_o.writable, out_res_o.fat_kind != KIND_FAT12)
  // A valid volume is never classed as too large.
  `FVG_ASSERT_IMPLY(a_valid_kind, clk_i, rst_ni,
    out_valid_o && out_res_o.volume_valid, out_res_o.fat_kind != KIND_TOO_LARGE)
  // A rejected boot sector yields zeroed fields.
  `FVG_ASSERT_IMPLY(a_reject_zero, clk_i, rst_ni,
    out_valid_o && !out_res_o.volume_valid && out_res_o.fat_kind != KIND_TOO_LARGE,
    out_res_o.sectors_in_volume == '0 && out_res_o.cluster_count == '0 &&
    out_res_o.chain_end_marker == '0)

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for fat_volume_geometry_top: requests go in, geometry results come out.
// Depends on fvg_pkg and the top module. A scoreboard class holds its own geometry predictor.
`timescale 1ns / 1ps
module tb_top;
  import fvg_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1250;
  localparam int unsigned HOLD_CYCLES     = 200;  // long receiver hold-off, fills the pipe
  localparam int unsigned DRAIN_CYCLES    = 40;   // extra wait after the last result, for strays
  localparam int unsigned MAX_PRINTED     = 100;

  // Scoreboard: predicts the geometry of every accepted request and checks results
  // against the oldest prediction still pending.
  class geometry_checker;
    fvg_res_t    expected_geometry[$];
    int unsigned accepted_count;
    int unsigned mismatch_count;

    function new();
      accepted_count = 0;
      mismatch_count = 0;
    endfunction

    // All sums, products and differences are kept at 32 bits so that they wrap.
    function fvg_res_t predict_geometry(fvg_req_t r);
      fvg_res_t    g;
      logic [31:0] bps, spc, total, fatlen, rootlen, dstart, dcount, clusters;
      g = '0;
      if ((r.jump_opcode != JMP_SHORT && r.jump_opcode != JMP_NEAR) ||
          r.sector_bytes == '0 || r.cluster_sectors == '0)
        return g;
      bps      = {16'b0, r.sector_bytes};
      spc      = {24'b0, r.cluster_sectors};
      total    = (r.total_sectors_small == '0) ? r.total_sectors_large
                                               : {16'b0, r.total_sectors_small};
      fatlen   = (r.fat_size_small == '0) ? r.fat_size_large : {16'b0, r.fat_size_small};
      rootlen  = ({16'b0, r.root_entries} * ROOT_ENTRY_BYTES + bps - 32'd1) / bps;
      dstart   = {16'b0, r.reserved_sectors} + {24'b0, r.fat_copies} * fatlen + rootlen;
      dcount   = total - dstart;
      clusters = dcount / spc;

      g.volume_valid = 1'b1;
      g.writable     = r.want_writable;
      if (clusters < FAT12_CLUSTER_LIMIT) begin
        g.fat_kind         = KIND_FAT12;
        g.writable         = 1'b0;
        g.chain_end_marker = EOC_FAT12;
      end else if (clusters < FAT16_CLUSTER_LIMIT) begin
        g.fat_kind         = KIND_FAT16;
        g.chain_end_marker = EOC_FAT16;
      end else if (clusters < FAT32_CLUSTER_LIMIT) begin
        g.fat_kind         = KIND_FAT32;
        g.chain_end_marker = EOC_FAT32;
      end else begin
        g.fat_kind         = KIND_TOO_LARGE;
        g.volume_valid     = 1'b0;
        g.chain_end_marker = EOC_FAT32;
      end

      if (g.fat_kind == KIND_FAT32)
        g.root_first_sector = (r.root_start_cluster - FIRST_DATA_CLUSTER) * spc + dstart;
      else
        g.root_first_sector = dstart - rootlen;

      g.sectors_in_volume = total;
      g.fat_length        = fatlen;
      g.root_dir_length   = rootlen[ROOT_LEN_W-1:0];
      g.fat_start_sector  = r.reserved_sectors;
      g.data_start_sector = dstart;
      g.data_sector_count = dcount;
      g.cluster_count     = clusters;
      return g;
    endfunction

    function void note_request(fvg_req_t r);
      expected_geometry = {expected_geometry, predict_geometry(r)};
      accepted_count++;
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
        $display("%0t ns: geometry mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(fvg_res_t got);
      fvg_res_t want;
      if (expected_geometry.size() == 0) begin
        report_mismatch("result offered with no request pending");
        return;
      end
      want = expected_geometry.pop_front();
      compare_field("volume_valid",      got.volume_valid,      want.volume_valid);
      compare_field("fat_kind",          got.fat_kind,          want.fat_kind);
      compare_field("writable",          got.writable,          want.writable);
      compare_field("sectors_in_volume", got.sectors_in_volume, want.sectors_in_volume);
      compare_field("fat_length",        got.fat_length,        want.fat_length);
      compare_field("root_dir_length",   got.root_dir_length,   want.root_dir_length);
      compare_field("fat_start_sector",  got.fat_start_sector,  want.fat_start_sector);
      compare_field("data_start_sector", got.data_start_sector, want.data_start_sector);
      compare_field("data_sector_count", got.data_sector_count, want.data_sector_count);
      compare_field("cluster_count",     got.cluster_count,     want.cluster_count);
      compare_field("root_first_sector", got.root_first_sector, want.root_first_sector);
      compare_field("chain_end_marker",  got.chain_end_marker,  want.chain_end_marker);
    endtask
  endclass

  // Clock, reset and every block input start at known values.
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     out_stall_i = 1'b0;
  fvg_req_t in_req_i    = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  fvg_res_t out_res_o;

  geometry_checker chk = new();

  always #4 clk_i = ~clk_i;

  fat_volume_geometry_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  // Watch both channels at the edge itself: values read here are those from before the
  // edge, so acceptance is judged exactly as the block judges it.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      chk.note_request(in_req_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      chk.check_result(out_res_o);
  end

  // Sender gaps: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      return 0;
    else if (pick < 85)
      return $urandom_range(1, 3);
    else if (pick < 97)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 60);
  endfunction

  // Offer one request after a gap and hold it until the block takes it. Keep valid high
  // across back-to-back requests so that it sees one assignment per edge only.
  task automatic send_request(input fvg_req_t r, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Build a well-formed request with random content whose data area holds the given
  // number of clusters. spc_cap bounds the cluster size so that large counts need not
  // wrap; when they do wrap the prediction still holds, only the kind drifts.
  function automatic fvg_req_t shape_volume(int unsigned clusters, int unsigned spc_cap);
    fvg_req_t    r;
    int unsigned bps, spc, fatlen, rootlen, dstart, total, pick;
    r = '0;
    r.jump_opcode = $urandom_range(0, 1) ? JMP_SHORT : JMP_NEAR;

    pick = $urandom_range(0, 9);
    bps  = (pick < 7) ? (32'd512 << $urandom_range(0, 3)) : $urandom_range(1, 65535);
    r.sector_bytes = bps[15:0];

    spc = $urandom_range(0, 9) < 7 ? (32'd1 << $urandom_range(0, 7)) : $urandom_range(1, 255);
    if (spc > spc_cap)
      spc = spc_cap;
    r.cluster_sectors = spc[7:0];

    r.reserved_sectors = 16'($urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                                       : $urandom_range(1, 64));
    r.fat_copies       = 8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(1, 2));
    pick = $urandom_range(0, 9);
    r.root_entries = (pick < 3) ? 16'd0 : (pick < 6) ? 16'd512 : 16'($urandom_range(0, 65535));

    fatlen = $urandom_range(0, 4) == 0 ? $urandom_range(1, 1 << 22) : $urandom_range(1, 65535);
    if (fatlen < 65536 && $urandom_range(0, 1)) begin
      r.fat_size_small = fatlen[15:0];
      r.fat_size_large = $urandom;
    end else begin
      r.fat_size_large = fatlen;
    end

    rootlen = (r.root_entries * ROOT_ENTRY_BYTES + bps - 1) / bps;
    dstart  = r.reserved_sectors + r.fat_copies * fatlen + rootlen;
    total   = dstart + clusters * spc + $urandom_range(0, spc - 1);
    if (total < 65536 && total != 0 && $urandom_range(0, 1)) begin
      r.total_sectors_small = total[15:0];
      r.total_sectors_large = $urandom;
    end else begin
      r.total_sectors_large = total;
    end

    // Mostly sane root clusters, sometimes below the first data cluster so it wraps.
    pick = $urandom_range(0, 19);
    r.root_start_cluster = (pick == 0) ? $urandom_range(0, 1) :
                           (pick == 1) ? $urandom : $urandom_range(2, 1000);
    r.want_writable = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Random request aimed at one of the kinds, or at a kind boundary.
  function automatic fvg_req_t random_volume();
    int unsigned pick, edge_count;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      return shape_volume($urandom_range(0, 4084), 255);
    else if (pick < 55)
      return shape_volume($urandom_range(4085, 65524), 255);
    else if (pick < 80)
      return shape_volume($urandom_range(65525, 4000000), 64);
    else if (pick < 88)
      return shape_volume($urandom_range(268435445, 32'h3FFF_FFFF), 4);
    case ($urandom_range(0, 2))
      0:       edge_count = FAT12_CLUSTER_LIMIT;
      1:       edge_count = FAT16_CLUSTER_LIMIT;
      default: edge_count = FAT32_CLUSTER_LIMIT;
    endcase
    return shape_volume(edge_count + $urandom_range(0, 2) - 1, 1);
  endfunction

  // Break a good request: wrong jump byte, or a zero sector or cluster size.
  function automatic fvg_req_t break_volume(fvg_req_t r);
    logic [7:0] jmp;
    case ($urandom_range(0, 2))
      0: begin
        jmp = 8'($urandom_range(0, 255));
        if (jmp == JMP_SHORT || jmp == JMP_NEAR)
          jmp = jmp ^ 8'h01;
        r.jump_opcode = jmp;
      end
      1:       r.sector_bytes    = '0;
      default: r.cluster_sectors = '0;
    endcase
    return r;
  endfunction

  // Fully random fields: toggles every input bit, mostly rejected by the jump check.
  function automatic fvg_req_t noise_volume();
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(fvg_req_t)-1:0];
  endfunction

  // Receiver: random stalls of mixed length, quiet stretches, and two long hold-offs
  // while the sender keeps offering, so the pipe fills and in_stall_o rises.
  initial begin : receiver
    int unsigned holds_done;
    int unsigned pick;
    int unsigned len;
    holds_done = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_done < 2 && chk.accepted_count >= (holds_done + 1) * 400) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(50, 150);
        end else if (pick < 55) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(1, 6);
        end else if (pick < 92) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          len = $urandom_range(5, 40);
        end
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Sender: reset, directed requests, random requests, then drain and judge.
  initial begin : sender
    fvg_req_t    directed[$];
    fvg_req_t    r;
    int unsigned pick;
    bit          no_gaps;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reject cases: wrong jump bytes, zero sector size, zero cluster size.
    directed = {directed, fvg_req_t'{8'h00, 16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880,
                                     32'd0, 16'd9, 32'd0, 32'd2, 1'b1}};
    directed = {directed, fvg_req_t'{8'hFF, 16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880,
                                     32'd0, 16'd9, 32'd0, 32'd2, 1'b1}};
    directed = {directed, fvg_req_t'{8'hEA, 16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880,
                                     32'd0, 16'd9, 32'd0, 32'd2, 1'b1}};
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'd0, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880,
                                     32'd0, 16'd9, 32'd0, 32'd2, 1'b1}};
    directed = {directed, fvg_req_t'{JMP_NEAR, 16'd512, 8'd0, 16'd1, 8'd2, 16'd224, 16'd2880,
                                     32'd0, 16'd9, 32'd0, 32'd2, 1'b1}};
    // Floppy-sized FAT12: writable forced low.
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880,
                                     32'hDEAD_BEEF, 16'd9, 32'hCAFE_F00D, 32'd2, 1'b1}};
    // Mid-size volume on the 32-bit total field.
    directed = {directed, fvg_req_t'{JMP_NEAR, 16'd512, 8'd4, 16'd4, 8'd2, 16'd512, 16'd0,
                                     32'd409600, 16'd256, 32'd0, 32'd2, 1'b1}};
    // FAT32 with root cluster two, then zero and one so the root sector wraps.
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'd512, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0,
                                     32'd16777216, 16'd0, 32'd16368, 32'd2, 1'b1}};
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'd512, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0,
                                     32'd16777216, 16'd0, 32'd16368, 32'd0, 1'b0}};
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'd512, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0,
                                     32'd16777216, 16'd0, 32'd16368, 32'd1, 1'b1}};
    // Too many clusters on a maximal total.
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'd512, 8'd1, 16'd1, 8'd1, 16'd0, 16'd0,
                                     32'hFFFF_FFFF, 16'd0, 32'd1, 32'd5, 1'b1}};
    // Every field but the jump byte at its top value.
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF,
                                     16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 1'b1}};
    // Smallest legal sizes, everything else zero.
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'd1, 8'd1, 16'd0, 8'd0, 16'd0, 16'd0,
                                     32'd0, 16'd0, 32'd0, 32'd0, 1'b0}};
    // Data start past the end of the volume: the data count wraps.
    directed = {directed, fvg_req_t'{JMP_NEAR, 16'd512, 8'd1, 16'd1000, 8'd2, 16'd224, 16'd100,
                                     32'd0, 16'd9, 32'd0, 32'd2, 1'b1}};
    // One-byte sectors with the largest root directory: the widest root length.
    directed = {directed, fvg_req_t'{JMP_SHORT, 16'd1, 8'd2, 16'd8, 8'd1, 16'hFFFF, 16'd0,
                                     32'h8000_0000, 16'd16, 32'd0, 32'd2, 1'b1}};
    // Either side of each kind boundary, and the largest cluster count.
    directed = {directed, shape_volume(FAT12_CLUSTER_LIMIT - 1, 4)};
    directed = {directed, shape_volume(FAT12_CLUSTER_LIMIT, 4)};
    directed = {directed, shape_volume(FAT16_CLUSTER_LIMIT - 1, 4)};
    directed = {directed, shape_volume(FAT16_CLUSTER_LIMIT, 4)};
    directed = {directed, shape_volume(FAT32_CLUSTER_LIMIT - 1, 1)};
    directed = {directed, shape_volume(FAT32_CLUSTER_LIMIT, 1)};
    directed = {directed, shape_volume(32'hFFFF_FFFF, 1)};

    foreach (directed[i])
      send_request(directed[i], pick_gap());

    // Random part: mostly well-formed volumes, some broken, some pure noise. Every
    // two hundred requests, run a burst with no sender gaps at all.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      no_gaps = (i % 200) < 40;
      pick    = $urandom_range(0, 99);
      if (pick < 15)
        r = noise_volume();
      else if (pick < 25)
        r = break_volume(random_volume());
      else
        r = random_volume();
      send_request(r, no_gaps ? 0 : pick_gap());
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every pending result, then a little longer for strays.
    while (chk.expected_geometry.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (chk.mismatch_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : watchdog
    #6000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/fvg_pkg.sv
sv/fat_volume_geometry_top.sv
tb/sv/tb_top.sv
